// File: hw/rtl/spbpl_pkg.sv
// shared types, widths and band / height tables for the spectrum bar block
package spbpl_pkg;

   localparam int NumBands  = 16;
   localparam int BinW      = 8;
   localparam int ValueW    = 16;
   localparam int PeakW     = 15;
   localparam int BandW     = 4;
   localparam int HeightW   = 6;
   localparam int HeightMax = 32;

   typedef logic [BinW-1:0]    bin_type;
   typedef logic [ValueW-1:0]  value_type;
   typedef logic [PeakW-1:0]   peak_type;
   typedef logic [BandW-1:0]   band_type;
   typedef logic [HeightW-1:0] height_type;

   // bin that belongs to no band
   localparam bin_type BIN_NONE = 8'd255;

   // band that closes a frame
   localparam band_type LAST_BAND = 4'd15;

   // first and last bin of each band
   localparam bin_type BAND_FIRST [NumBands] = '{
      8'd0,   8'd1,   8'd2,   8'd3,   8'd5,   8'd7,   8'd10,  8'd14,
      8'd20,  8'd28,  8'd40,  8'd54,  8'd74,  8'd101, 8'd137, 8'd187
   };
   localparam bin_type BAND_LAST [NumBands] = '{
      8'd0,   8'd1,   8'd2,   8'd4,   8'd6,   8'd9,   8'd13,  8'd19,
      8'd27,  8'd39,  8'd53,  8'd73,  8'd100, 8'd136, 8'd186, 8'd254
   };

   // least peak reaching each bar height: entry k-1 is least p with p^7 >= 2^(3k)
   localparam peak_type HEIGHT_STEP [HeightMax] = '{
      15'd2,    15'd2,    15'd3,    15'd4,    15'd5,    15'd6,    15'd8,    15'd11,
      15'd15,   15'd20,   15'd27,   15'd36,   15'd48,   15'd64,   15'd87,   15'd116,
      15'd157,  15'd211,  15'd283,  15'd381,  15'd512,  15'd690,  15'd928,  15'd1249,
      15'd1681, 15'd2262, 15'd3044, 15'd4096, 15'd5513, 15'd7420, 15'd9987, 15'd13441
   };

   // band lookup result for one bin index
   typedef struct packed {
      logic     in_band;
      band_type band;
      logic     first;
      logic     last;
   } band_info_type;

endpackage

// File: hw/rtl/spbpl_band_map.sv
// maps a bin index to its log-spaced band and flags its first and last bin
module spbpl_band_map
   import spbpl_pkg::*;
(
   input  bin_type       bin_index,
   output band_info_type info
);

   logic [BandW:0] count;

   // band number is the count of band starts above band 0 that the index reaches
   always_comb begin
      count = '0;
      for (int b = 1; b < NumBands; b++) begin
         if (bin_index >= BAND_FIRST[b]) begin
            count = count + 1'b1;
         end
      end
   end

   always_comb begin
      info.in_band = (bin_index != BIN_NONE);
      info.band    = count[BandW-1:0];
      info.first   = (bin_index == BAND_FIRST[count[BandW-1:0]]);
      info.last    = (bin_index == BAND_LAST[count[BandW-1:0]]);
   end

endmodule

// File: hw/rtl/spbpl_bar_height.sv
// turns a band peak into a bar height by counting the thresholds it reaches
module spbpl_bar_height
   import spbpl_pkg::*;
(
   input  peak_type   peak,
   output height_type height
);

   // every threshold compare is independent; the count is the height
   always_comb begin
      height = '0;
      for (int k = 0; k < HeightMax; k++) begin
         if (peak >= HEIGHT_STEP[k]) begin
            height = height + 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/spectrum_band_peak_log_bars_core.sv
// top level: spectrum bins in, one log-scaled bar height per band out
//
// Usage:
//  - req channel carries one spectrum bin per transfer: value and bin index,
//    bins 0..255 of a frame in ascending order. Bin 255 belongs to no band.
//  - rsp channel carries one bar height per band, issued on the band's last
//    bin; rsp_tlast marks band 15, the end of the frame.
//  - csr_wr_en / csr_wr_data write the enable bit. While it is low, bins are
//    taken and dropped and the band peak holds its value. Write it only when
//    the block is idle.
//  - path: a bin taken goes into the input register, and its bar then moves
//    into the result register, which drives rsp.
//  - throughput: one bin per cycle while no bar is stalled on rsp, set by the
//    single compare / threshold pass between the two registers.
//  - when the receiver stalls, the bar holds in the result register while the
//    input register keeps taking bins that close no band; req_tready drops
//    only when a bin that closes a band is waiting behind a stalled bar.
//  - reset (synchronous, active high) empties both registers, clears the
//    band peak and leaves the block disabled.
module spectrum_band_peak_log_bars_core
   import spbpl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // bin input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // [15:0] bin_value (signed), [23:16] bin_index
   // bar output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [3:0] band_index, [9:4] bar_height, [15:10] zero
   output logic        rsp_tlast,    // frame_last
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data   // enable
);

   // input register
   logic          s1_valid_ff, s1_valid_in;
   value_type     s1_value_ff;
   bin_type       s1_index_ff;

   // state and config
   logic          enable_ff, enable_in;
   peak_type      band_peak_ff, band_peak_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   band_type      rsp_band_ff;
   height_type    rsp_height_ff;
   logic          rsp_last_ff;

   band_info_type info;
   peak_type      peak_base;
   peak_type      peak_new;
   height_type    height;
   logic          active;
   logic          emit;
   logic          out_free;
   logic          s1_advance;
   logic          req_take;

   spbpl_band_map u_band_map (
      .bin_index (s1_index_ff),
      .info      (info)
   );

   // running positive peak; restarts on a band's first bin
   always_comb begin
      peak_base = info.first ? '0 : band_peak_ff;
      if (!s1_value_ff[ValueW-1] && (s1_value_ff[PeakW-1:0] > peak_base)) begin
         peak_new = s1_value_ff[PeakW-1:0];
      end else begin
         peak_new = peak_base;
      end
   end

   spbpl_bar_height u_bar_height (
      .peak   (peak_new),
      .height (height)
   );

   // handshake between the two registers
   always_comb begin
      active     = s1_valid_ff && enable_ff && info.in_band;
      emit       = active && info.last;
      out_free   = !rsp_valid_ff || rsp_tready;
      s1_advance = s1_valid_ff && (out_free || !emit);
      req_tready = !s1_valid_ff || s1_advance;
      req_take   = req_tvalid && req_tready;
   end

   // next values of control and state
   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
      enable_in    = csr_wr_en ? csr_wr_data : enable_ff;
      band_peak_in = band_peak_ff;
      if (s1_advance && active) begin
         band_peak_in = info.last ? '0 : peak_new;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         enable_ff    <= 1'b0;
         band_peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         enable_ff    <= enable_in;
         band_peak_ff <= band_peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_value_ff <= req_tdata[ValueW-1:0];
         s1_index_ff <= req_tdata[ValueW+BinW-1:ValueW];
      end
   end

   // payload of the result register
   always_ff @(posedge clock) begin
      if (s1_advance && emit) begin
         rsp_band_ff   <= info.band;
         rsp_height_ff <= height;
         rsp_last_ff   <= (info.band == LAST_BAND);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_height_ff, rsp_band_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/spbpl_checker.sv
// port-level checks on the spectrum bar block, bound to the top level
module spbpl_checker
   import spbpl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_wr_en,
   input logic        csr_wr_data
);

   // a stalled bar holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("bar changed while stalled");

   // end of frame flag goes with the last band and only with it
   a_last_band: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[3:0] == LAST_BAND)))
      else $error("frame_last does not match band 15");

   // bar height saturates at the table size and padding stays zero
   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:4] <= 6'd32) && (rsp_tdata[15:10] == 6'd0))
      else $error("bar height out of range");

   // reset leaves no bar pending
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("bar pending after reset");

endmodule

bind spectrum_band_peak_log_bars_core spbpl_checker u_spbpl_checker (.*);
